### hdl/rth_pkg.sv
package rth_pkg;

    // channel byte width, also the width of every divisor and remainder
    localparam int CHAN_W = 8;

    // quotient bits resolved in each divider stage
    localparam int DIV_STEPS = 4;

    localparam int HUE_W = 16;
    localparam int SAT_W = 16;
    localparam int SUM_W = CHAN_W + 1;

    // hue offsets in degrees for each maximum channel
    localparam logic [8:0] BASE_RED   = 9'd360;
    localparam logic [8:0] BASE_GREEN = 9'd120;
    localparam logic [8:0] BASE_BLUE  = 9'd240;

    // twice full scale of one channel
    localparam logic [SUM_W-1:0] SUM_FULL = SUM_W'(510);

    localparam logic [SAT_W-1:0] SAT_MAX = '1;

    // which channel holds the maximum, red first on a tie
    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

endpackage

### hdl/rth_div.sv
module rth_div
    import rth_pkg::*;
#(
    parameter int QW    = 17,
    parameter int STEPS = 4
)
(
    input  logic                          clk,
    input  logic [(QW+STEPS-1)/STEPS-1:0] en,
    input  logic [QW+CHAN_W-1:0]          dividend,
    input  logic [CHAN_W-1:0]             divisor,
    output logic [QW-1:0]                 quotient
);

    localparam int NS = (QW + STEPS - 1) / STEPS;

    logic [CHAN_W-1:0] rem_in   [NS];
    logic [QW-1:0]     lo_in    [NS];
    logic [QW-1:0]     q_in     [NS];
    logic [CHAN_W-1:0] dv_in    [NS];

    logic [CHAN_W-1:0] rem_next [NS];
    logic [QW-1:0]     lo_next  [NS];
    logic [QW-1:0]     q_next   [NS];

    logic [CHAN_W-1:0] rem_reg  [NS];
    logic [QW-1:0]     lo_reg   [NS];
    logic [QW-1:0]     q_reg    [NS];
    logic [CHAN_W-1:0] dv_reg   [NS];

    // stage inputs: the operands for the first stage, the previous stage otherwise
    always_comb
    begin
        rem_in[0] = dividend[QW+CHAN_W-1:QW];
        lo_in[0]  = dividend[QW-1:0];
        q_in[0]   = '0;
        dv_in[0]  = divisor;
        for (int j = 1; j < NS; j++)
        begin
            rem_in[j] = rem_reg[j-1];
            lo_in[j]  = lo_reg[j-1];
            q_in[j]   = q_reg[j-1];
            dv_in[j]  = dv_reg[j-1];
        end
    end

    // restoring division, one quotient bit per step
    always_comb
    begin
        logic [CHAN_W:0]   trial;
        logic [CHAN_W-1:0] r;
        logic [QW-1:0]     l;
        logic [QW-1:0]     q;
        for (int j = 0; j < NS; j++)
        begin
            r = rem_in[j];
            l = lo_in[j];
            q = q_in[j];
            for (int i = 0; i < STEPS; i++)
            begin
                if (j * STEPS + i < QW)
                begin
                    trial = {r, l[QW-1]};
                    l     = {l[QW-2:0], 1'b0};
                    if (trial >= {1'b0, dv_in[j]})
                    begin
                        r = CHAN_W'(trial - {1'b0, dv_in[j]});
                        q = {q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r = trial[CHAN_W-1:0];
                        q = {q[QW-2:0], 1'b0};
                    end
                end
            end
            rem_next[j] = r;
            lo_next[j]  = l;
            q_next[j]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next[j];
                lo_reg[j]  <= lo_next[j];
                q_reg[j]   <= q_next[j];
                dv_reg[j]  <= dv_in[j];
            end
        end
    end

    assign quotient = q_reg[NS-1];

endmodule

### hdl/rgb_to_hsl_pixel.sv
// RGB to HSL conversion, one pixel per item. Input tdata carries alpha, blue, green and red
// bytes from the lowest bit up; each pixel gives one result carrying alpha, hue (degrees with
// HUE_FRAC_BITS fraction bits, truncated, wrapped below 360), saturation (SAT_FRAC_BITS
// fraction bits, truncated, saturating at all ones) and the sum cmax + cmin, which is
// lightness times 510. Grey pixels give hue and saturation of zero; on ties for the maximum
// red wins over green and green over blue. The block takes one pixel every clock unless
// its pipe is full behind a stalled output, and holds up to one item in each stage, so a stalled
// output fills bubbles before it pushes back. The two restoring dividers for hue and saturation
// run side by side and resolve four quotient bits in each stage, with enough stages for QW
// quotient bits, where QW is the larger of 9 + HUE_FRAC_BITS, SAT_FRAC_BITS + 1 and 17.
module rgb_to_hsl_pixel
    import rth_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 7,
    parameter int SAT_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // alpha_in, blue, green, red

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // alpha_out, hue, saturation, lightness_sum, zero pad
);

    // quotient width: hue reaches 420 degrees before the wrap, saturation 1.0, and
    // the quotient must be wide enough to see saturation past all ones
    localparam int QW_HUE = 9 + HUE_FRAC_BITS;
    localparam int QW_SAT = SAT_FRAC_BITS + 1;
    localparam int QW_A   = (QW_HUE > QW_SAT) ? QW_HUE : QW_SAT;
    localparam int QW     = (QW_A > SAT_W + 1) ? QW_A : SAT_W + 1;
    localparam int DW     = QW + CHAN_W;
    localparam int NS     = (QW + DIV_STEPS - 1) / DIV_STEPS;

    // stages: channel max/min, operand set-up, divider stages, output register
    localparam int P      = NS + 3;

    localparam logic [QW-1:0] HUE_FULL = QW'(360) << HUE_FRAC_BITS;
    localparam logic [QW-1:0] SAT_ONE  = QW'(1) << SAT_FRAC_BITS;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [SUM_W-1:0]  sum;
        logic              grey;
    } side_t;

    // ------------------------------------------------------------------
    // stage control: each stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [P-1:0] valid_reg;
    logic [P-1:0] valid_next;
    logic [P-1:0] valid_in;
    logic [P:0]   en;

    always_comb
    begin
        en[P] = m_axis_tready;
        for (int k = P - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign valid_in = {valid_reg[P-2:0], s_axis_tvalid};

    always_comb
    begin
        for (int k = 0; k < P; k++)
        begin
            valid_next[k] = en[k] ? valid_in[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = en[0];

    // ------------------------------------------------------------------
    // stage a: unpack and find the largest and smallest channel
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] in_alpha, in_b, in_g, in_r;
    logic [CHAN_W-1:0] max_rg, min_rg, max_next, min_next;

    logic [CHAN_W-1:0] a_alpha_reg, a_r_reg, a_g_reg, a_b_reg;
    logic [CHAN_W-1:0] a_max_reg, a_min_reg;

    assign in_alpha = s_axis_tdata[7:0];
    assign in_b     = s_axis_tdata[15:8];
    assign in_g     = s_axis_tdata[23:16];
    assign in_r     = s_axis_tdata[31:24];

    assign max_rg   = (in_g > in_r) ? in_g : in_r;
    assign min_rg   = (in_g < in_r) ? in_g : in_r;
    assign max_next = (in_b > max_rg) ? in_b : max_rg;
    assign min_next = (in_b < min_rg) ? in_b : min_rg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_alpha_reg <= in_alpha;
            a_r_reg     <= in_r;
            a_g_reg     <= in_g;
            a_b_reg     <= in_b;
            a_max_reg   <= max_next;
            a_min_reg   <= min_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: spread, sum, hue numerator and saturation denominator
    // ------------------------------------------------------------------
    max_sel_t           sel;
    logic [CHAN_W-1:0]  d;
    logic [SUM_W-1:0]   sum;
    logic               grey;
    logic signed [8:0]  diff;
    logic [8:0]         base;
    logic signed [17:0] diff_x;
    logic [17:0]        num;
    logic [CHAN_W-1:0]  den;

    logic [DW-1:0]      hue_num_next, sat_num_next;
    logic [CHAN_W-1:0]  hue_dv_next, sat_dv_next;

    logic [CHAN_W-1:0]  b_alpha_reg;
    logic [SUM_W-1:0]   b_sum_reg;
    logic               b_grey_reg;
    logic [DW-1:0]      b_hue_num_reg, b_sat_num_reg;
    logic [CHAN_W-1:0]  b_hue_dv_reg, b_sat_dv_reg;

    assign d    = a_max_reg - a_min_reg;
    assign sum  = SUM_W'(a_max_reg) + SUM_W'(a_min_reg);
    assign grey = (d == '0);

    always_comb
    begin
        if (a_max_reg == a_r_reg)
        begin
            sel = MAX_RED;
        end
        else if (a_max_reg == a_g_reg)
        begin
            sel = MAX_GREEN;
        end
        else
        begin
            sel = MAX_BLUE;
        end
    end

    always_comb
    begin
        unique case (sel)
            MAX_RED:
            begin
                diff = signed'({1'b0, a_g_reg}) - signed'({1'b0, a_b_reg});
                base = BASE_RED;
            end
            MAX_GREEN:
            begin
                diff = signed'({1'b0, a_b_reg}) - signed'({1'b0, a_r_reg});
                base = BASE_GREEN;
            end
            default:
            begin
                diff = signed'({1'b0, a_r_reg}) - signed'({1'b0, a_g_reg});
                base = BASE_BLUE;
            end
        endcase
    end

    // 60 * diff + base * d is never negative and stays below 2^17
    assign diff_x = 18'(diff);
    assign num    = 18'(diff_x * 18'sd60) + 18'(base) * 18'(d);

    // distance of the sum from either end of its range
    assign den = (sum <= SUM_W'(255)) ? sum[CHAN_W-1:0]
                                      : CHAN_W'(SUM_FULL - sum);

    // grey pixels divide zero by one, the result is masked at the end
    always_comb
    begin
        if (grey)
        begin
            hue_num_next = '0;
            sat_num_next = '0;
            hue_dv_next  = CHAN_W'(1);
            sat_dv_next  = CHAN_W'(1);
        end
        else
        begin
            hue_num_next = DW'(num[16:0]) << HUE_FRAC_BITS;
            sat_num_next = DW'(d) << SAT_FRAC_BITS;
            hue_dv_next  = d;
            sat_dv_next  = den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_alpha_reg   <= a_alpha_reg;
            b_sum_reg     <= sum;
            b_grey_reg    <= grey;
            b_hue_num_reg <= hue_num_next;
            b_sat_num_reg <= sat_num_next;
            b_hue_dv_reg  <= hue_dv_next;
            b_sat_dv_reg  <= sat_dv_next;
        end
    end

    // ------------------------------------------------------------------
    // divider stages, with alpha, sum and the grey flag carried alongside
    // ------------------------------------------------------------------
    logic [QW-1:0] hue_q, sat_q;
    side_t         side_in  [NS];
    side_t         side_reg [NS];

    rth_div #(
        .QW    (QW),
        .STEPS (DIV_STEPS)
    ) u_hue_div (
        .clk      (clk),
        .en       (en[NS+1:2]),
        .dividend (b_hue_num_reg),
        .divisor  (b_hue_dv_reg),
        .quotient (hue_q)
    );

    rth_div #(
        .QW    (QW),
        .STEPS (DIV_STEPS)
    ) u_sat_div (
        .clk      (clk),
        .en       (en[NS+1:2]),
        .dividend (b_sat_num_reg),
        .divisor  (b_sat_dv_reg),
        .quotient (sat_q)
    );

    always_comb
    begin
        side_in[0] = '{alpha: b_alpha_reg, sum: b_sum_reg, grey: b_grey_reg};
        for (int j = 1; j < NS; j++)
        begin
            side_in[j] = side_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (en[2+j])
            begin
                side_reg[j] <= side_in[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: wrap hue, clamp saturation, register the result
    // ------------------------------------------------------------------
    side_t             side_last;
    logic [QW-1:0]     hue_wrap;
    logic [HUE_W-1:0]  hue_next;
    logic [SAT_W-1:0]  sat_next;

    logic [CHAN_W-1:0] alpha_out_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [SAT_W-1:0]  sat_reg;
    logic [SUM_W-1:0]  sum_out_reg;

    assign side_last = side_reg[NS-1];
    assign hue_wrap  = (hue_q >= HUE_FULL) ? hue_q - HUE_FULL : hue_q;

    always_comb
    begin
        if (side_last.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_wrap[HUE_W-1:0];
            sat_next = (sat_q > QW'(SAT_MAX)) ? SAT_MAX : sat_q[SAT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[P-1])
        begin
            alpha_out_reg <= side_last.alpha;
            hue_reg       <= hue_next;
            sat_reg       <= sat_next;
            sum_out_reg   <= side_last.sum;
        end
    end

    assign m_axis_tvalid = valid_reg[P-1];
    assign m_axis_tdata  = {7'b0, sum_out_reg, sat_reg, hue_reg, alpha_out_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // hue never needs more than one wrap
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS+1] |-> (hue_wrap < HUE_FULL))
    else $error("hue quotient beyond one wrap");

    // the spread never exceeds the saturation denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS+1] && !side_last.grey) |-> (sat_q <= SAT_ONE))
    else $error("saturation quotient above one");

    // input back-pressure only comes from a full pipe behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&valid_reg)))
    else $error("input stalled without cause");

    // a stalled output item stays put for the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(hue_reg)
                                                && $stable(sat_reg)))
    else $error("stalled result changed");

endmodule

### tb/sv/tb_top.sv
module tb_top;
    import rth_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // fraction widths, matching the defaults of the block
    localparam int HUE_FRAC = 7;
    localparam int SAT_FRAC = 16;

    // pipeline depth at the default fraction widths, plus a little slack
    localparam int PIPE_LAT = 8;
    localparam int SETTLE_CYCLES = PIPE_LAT + 4;

    // full turn of hue in fixed point
    localparam longint HUE_TURN = longint'(360) << HUE_FRAC;

    // one expected hsl item, fields as they sit in m_axis_tdata
    typedef struct {
        logic [CHAN_W-1:0] alpha;
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [SUM_W-1:0]  light_sum;
    } hsl_item_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // alpha_in, blue, green, red

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // alpha_out, hue, saturation, lightness_sum, zero pad

    // hsl items still owed by the block, oldest first
    hsl_item_t   pending_hsl[$];

    int          mismatch_count = 0;

    // idling of each side, in percent of cycles
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // cycles left in a long output hold-off
    int          hold_left = 0;

    rgb_to_hsl_pixel i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1ms;
        $display("FAIL rgb_to_hsl_pixel");
        $finish;
    end

    // pack a pixel, alpha in the lowest byte and red in the highest
    function automatic logic [31:0] pixel(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue, input logic [7:0] alpha);
        return {red, green, blue, alpha};
    endfunction

    // exact integer rgb to hsl conversion of one pixel
    function automatic hsl_item_t rgb_to_hsl(input logic [31:0] px);
        hsl_item_t res;
        max_sel_t  top;
        int        r;
        int        g;
        int        b;
        int        cmax;
        int        cmin;
        int        d;
        int        diff;
        int        base;
        int        mid_gap;
        int        den;
        longint    num;
        longint    quo;

        res.alpha = px[7:0];
        b = px[15:8];
        g = px[23:16];
        r = px[31:24];

        // strict compares keep red ahead of green and green ahead of blue on a tie
        cmax = r;
        top  = MAX_RED;
        if (g > cmax)
        begin
            cmax = g;
            top  = MAX_GREEN;
        end
        if (b > cmax)
        begin
            cmax = b;
            top  = MAX_BLUE;
        end
        cmin = r;
        if (g < cmin)
            cmin = g;
        if (b < cmin)
            cmin = b;

        d = cmax - cmin;
        res.light_sum = SUM_W'(cmax + cmin);
        res.hue = '0;
        res.sat = '0;

        // grey leaves hue and saturation at zero
        if (d != 0)
        begin
            case (top)
                MAX_RED:
                begin
                    diff = g - b;
                    base = BASE_RED;
                end
                MAX_GREEN:
                begin
                    diff = b - r;
                    base = BASE_GREEN;
                end
                default:
                begin
                    diff = r - g;
                    base = BASE_BLUE;
                end
            endcase

            // numerator is never negative, so plain division truncates toward zero
            num = longint'(60 * diff + base * d) << HUE_FRAC;
            quo = num / d;
            if (quo >= HUE_TURN)
                quo = quo - HUE_TURN;
            res.hue = HUE_W'(quo);

            mid_gap = cmax + cmin - 255;
            if (mid_gap < 0)
                mid_gap = -mid_gap;
            den = 255 - mid_gap;
            if (den != 0)
            begin
                quo = (longint'(d) << SAT_FRAC) / den;
                res.sat = (quo > longint'(SAT_MAX)) ? SAT_MAX : SAT_W'(quo);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // compare one output item with the oldest owed item
    task automatic check_hsl(input logic [55:0] got);
        hsl_item_t want;

        if (pending_hsl.size() == 0)
        begin
            report_mismatch($sformatf("output item with none owed, tdata %h", got));
            return;
        end
        want = pending_hsl.pop_front();
        if (got[7:0] !== want.alpha)
            report_mismatch($sformatf("alpha_out %0d, wanted %0d", got[7:0], want.alpha));
        if (got[23:8] !== want.hue)
            report_mismatch($sformatf("hue %0d, wanted %0d", got[23:8], want.hue));
        if (got[39:24] !== want.sat)
            report_mismatch($sformatf("saturation %0d, wanted %0d", got[39:24], want.sat));
        if (got[48:40] !== want.light_sum)
            report_mismatch($sformatf("lightness_sum %0d, wanted %0d",
                                      got[48:40], want.light_sum));
    endtask

    // output monitor, values taken as they stood before the edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_hsl(m_axis_tdata);
    end

    // output side: a long hold-off when asked, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one pixel, with random idle cycles ahead of it, and wait for the handshake
    task automatic send_pixel(input logic [31:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // owed item recorded here so that a following drain cannot miss it
        pending_hsl.push_back(rgb_to_hsl(px));
    endtask

    // stop offering until every owed item has come out, then let the pipe settle
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_hsl.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random pixel, often grey or with a tie for the maximum
    function automatic logic [31:0] random_pixel();
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;

        a = 8'($urandom);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(11))
            0:
            begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: r = 8'hff;
            5: b = 8'h00;
            6: g = r + 8'($urandom_range(2));
            default: ;
        endcase
        return pixel(r, g, b, a);
    endfunction

    // extremes, each maximum channel, ties, hue wrap and full saturation
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(pixel(8'd0,   8'd0,   8'd0,   8'h00));   // black
        send_pixel(pixel(8'd255, 8'd255, 8'd255, 8'hff));   // white
        send_pixel(pixel(8'd128, 8'd128, 8'd128, 8'h5a));   // mid grey
        send_pixel(pixel(8'd255, 8'd0,   8'd0,   8'ha5));   // pure red, full saturation
        send_pixel(pixel(8'd0,   8'd255, 8'd0,   8'h01));   // pure green
        send_pixel(pixel(8'd0,   8'd0,   8'd255, 8'h80));   // pure blue
        send_pixel(pixel(8'd255, 8'd255, 8'd0,   8'h7f));   // red and green tie
        send_pixel(pixel(8'd0,   8'd255, 8'd255, 8'h33));   // green and blue tie
        send_pixel(pixel(8'd255, 8'd0,   8'd255, 8'hcc));   // red and blue tie
        send_pixel(pixel(8'd255, 8'd0,   8'd1,   8'h10));   // hue just short of a full turn
        send_pixel(pixel(8'd255, 8'd1,   8'd0,   8'h20));   // hue just above zero
        send_pixel(pixel(8'd10,  8'd0,   8'd0,   8'h40));   // dark, still fully saturated
        send_pixel(pixel(8'd1,   8'd0,   8'd0,   8'h02));   // smallest spread, darkest
        send_pixel(pixel(8'd255, 8'd245, 8'd245, 8'hfe));   // light, small spread
        send_pixel(pixel(8'd254, 8'd255, 8'd255, 8'h55));   // green max by one, near white
        send_pixel(pixel(8'd200, 8'd100, 8'd50,  8'haa));
        send_pixel(pixel(8'd50,  8'd200, 8'd100, 8'h99));
        send_pixel(pixel(8'd100, 8'd50,  8'd200, 8'h66));
        send_pixel(pixel(8'd0,   8'd128, 8'd255, 8'h0f));   // blue max, hue below 240
        send_pixel(pixel(8'd255, 8'd128, 8'd0,   8'hf0));   // orange
        send_pixel(pixel(8'd127, 8'd128, 8'd127, 8'h3c));   // near grey, lightness near half
        drain_block();
    endtask

    // random pixels under one idling mix
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_pixels);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_pixels) send_pixel(random_pixel());
        drain_block();
    endtask

    // hold the output off long enough that the block fills and pushes back on its input
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 80;
        repeat (40) send_pixel(random_pixel());
        drain_block();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 100);      // no idling on either side
        test_random_phase(56, 0, 100);     // sender idle
        test_random_phase(0, 56, 100);     // receiver stalling
        test_random_phase(31, 31, 100);    // both sides idle
        test_output_holdoff();

        if (mismatch_count == 0)
            $display("PASS rgb_to_hsl_pixel");
        else
            $display("FAIL rgb_to_hsl_pixel");
        $finish;
    end

endmodule
